>>> rtl/core/dslr_pkg.sv
// Shared types and constants for the double-step line rasterizer.
// No dependencies; imported by every module of the block.
package dslr_pkg;

  localparam int COORD_BITS_DEFAULT = 12;
  localparam int QUEUE_DEPTH        = 4;

  // Command codes
  localparam logic CMD_START = 1'b0;

  // Line kinds
  localparam logic [1:0] KIND_AXIS    = 2'd0;  // horizontal, vertical or single point
  localparam logic [1:0] KIND_SHALLOW = 2'd1;  // slope below one half
  localparam logic [1:0] KIND_HALF    = 2'd2;  // slope of one half or more

  // Per-item control carried from front to back
  typedef struct packed {
    logic       is_start;
    logic [1:0] kind;
    logic       swapped;
    logic       minor_neg;
  } dslr_ctrl_t;

endpackage

>>> rtl/core/dslr_front.sv
// Front end: takes input items, registers deltas, and works out the line setup.
// Depends on dslr_pkg.
module dslr_front import dslr_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                item_valid,
  output logic                                item_ready,
  input  logic                                command,
  input  logic [COORD_BITS-1:0]               x_start,
  input  logic [COORD_BITS-1:0]               y_start,
  input  logic [COORD_BITS-1:0]               x_end,
  input  logic [COORD_BITS-1:0]               y_end,
  output logic                                q_valid,
  input  logic                                q_ready,
  output dslr_ctrl_t                          ctrl,
  output logic [COORD_BITS-1:0]               fwd_major,
  output logic [COORD_BITS-1:0]               fwd_minor,
  output logic [COORD_BITS-1:0]               bwd_major,
  output logic [COORD_BITS-1:0]               bwd_minor,
  output logic signed [COORD_BITS+3:0]        decision,
  output logic signed [COORD_BITS+3:0]        threshold,
  output logic signed [COORD_BITS+3:0]        inc_two,
  output logic [COORD_BITS-3:0]               steps,
  output logic [1:0]                          leftover
);

  localparam int DEC_W = COORD_BITS + 4;

  typedef struct packed {
    logic [1:0]              kind;
    logic signed [DEC_W-1:0] dec;
    logic signed [DEC_W-1:0] thr;
    logic signed [DEC_W-1:0] inc2;
  } setup_t;

  // Decision terms for a major length l and minor length s
  function automatic setup_t line_setup(input logic [COORD_BITS-1:0] l,
                                        input logic [COORD_BITS-1:0] s);
    logic signed [DEC_W-1:0] ls;
    logic signed [DEC_W-1:0] ss;
    setup_t                  r;
    ls     = signed'({4'b0000, l});
    ss     = signed'({4'b0000, s});
    r.inc2 = (ss <<< 2) - (ls <<< 1);
    if (r.inc2 < 0) begin
      r.kind = KIND_SHALLOW;
      r.thr  = ss <<< 1;
      r.dec  = (ss <<< 2) - ls;
    end else begin
      r.kind = KIND_HALF;
      r.thr  = (ss - ls) <<< 1;
      r.dec  = (ss <<< 2) - ls - (ls <<< 1);
    end
    return r;
  endfunction

  // Stage register
  logic                  s1_valid;
  logic                  s1_start;
  logic [COORD_BITS-1:0] s1_xs, s1_ys, s1_xe, s1_ye;
  logic [COORD_BITS-1:0] s1_adx, s1_ady;
  logic                  s1_xneg, s1_yneg, s1_xeq, s1_yeq;

  logic [COORD_BITS:0]   dx_diff, dy_diff, dx_mag, dy_mag;
  logic                  take;

  assign dx_diff = {1'b0, x_end} - {1'b0, x_start};
  assign dy_diff = {1'b0, y_end} - {1'b0, y_start};
  assign dx_mag  = dx_diff[COORD_BITS] ? (~dx_diff + (COORD_BITS+1)'(1)) : dx_diff;
  assign dy_mag  = dy_diff[COORD_BITS] ? (~dy_diff + (COORD_BITS+1)'(1)) : dy_diff;

  assign item_ready = !s1_valid || q_ready;
  assign take       = item_valid && item_ready;
  assign q_valid    = s1_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      if (take) begin
        s1_valid <= 1'b1;
        s1_start <= (command == CMD_START);
        s1_xs    <= x_start;
        s1_ys    <= y_start;
        s1_xe    <= x_end;
        s1_ye    <= y_end;
        s1_adx   <= dx_mag[COORD_BITS-1:0];
        s1_ady   <= dy_mag[COORD_BITS-1:0];
        s1_xneg  <= dx_diff[COORD_BITS];
        s1_yneg  <= dy_diff[COORD_BITS];
        s1_xeq   <= (x_start == x_end);
        s1_yeq   <= (y_start == y_end);
      end else if (q_ready) begin
        s1_valid <= 1'b0;
      end
    end
  end

  // Setup from the stage register
  logic                  swap, major_neg;
  logic [COORD_BITS-1:0] a1, a2, b1, b2, len_major, len_less;
  setup_t                set_x, set_y, set_sel;

  assign set_x = line_setup(s1_adx, s1_ady);
  assign set_y = line_setup(s1_ady, s1_adx);

  always_comb begin
    ctrl.is_start = s1_start;
    if (s1_xeq || s1_yeq) begin
      swap           = s1_xeq;
      major_neg      = 1'b0;
      ctrl.kind      = KIND_AXIS;
      ctrl.minor_neg = 1'b0;
    end else begin
      swap           = (s1_ady > s1_adx);
      major_neg      = swap ? s1_yneg : s1_xneg;
      ctrl.kind      = swap ? set_y.kind : set_x.kind;
      ctrl.minor_neg = s1_xneg ^ s1_yneg;
    end
    ctrl.swapped = swap;
    a1        = swap ? s1_ys : s1_xs;
    a2        = swap ? s1_ye : s1_xe;
    b1        = swap ? s1_xs : s1_ys;
    b2        = swap ? s1_xe : s1_ye;
    len_major = swap ? s1_ady : s1_adx;
    set_sel   = swap ? set_y : set_x;
    len_less  = len_major - COORD_BITS'(1);

    if (s1_xeq || s1_yeq) begin
      // run from the lower coordinate
      fwd_major = (a1 < a2) ? a1 : a2;
      bwd_major = (a1 < a2) ? a2 : a1;
      fwd_minor = b1;
      bwd_minor = '0;
      decision  = '0;
      threshold = '0;
      inc_two   = '0;
      steps     = '0;
      leftover  = 2'd0;
    end else begin
      fwd_major = major_neg ? a2 : a1;
      fwd_minor = major_neg ? b2 : b1;
      bwd_major = major_neg ? a1 : a2;
      bwd_minor = major_neg ? b1 : b2;
      decision  = set_sel.dec;
      threshold = set_sel.thr;
      inc_two   = set_sel.inc2;
      steps     = len_less[COORD_BITS-1:2];
      leftover  = len_less[1:0];
    end
  end

endmodule

>>> rtl/core/dslr_queue.sv
// Small register queue between the front and back ends.
// Depends on dslr_pkg for the default depth.
module dslr_queue import dslr_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH  // power of two, 2 to 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  logic [WIDTH-1:0] wr_data,
  output logic             rd_valid,
  input  logic             rd_ready,
  output logic [WIDTH-1:0] rd_data
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push, pop;

  assign wr_ready = (count != CNT_W'(DEPTH));
  assign rd_valid = (count != '0);
  assign rd_data  = slots[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        slots[wr_ptr] <= wr_data;
        wr_ptr        <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

>>> rtl/core/dslr_back.sv
// Back end: holds the line state, emits one pixel per cycle into the output register unless it is stalled.
// Depends on dslr_pkg.
module dslr_back import dslr_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         q_valid,
  output logic                         q_ready,
  input  dslr_ctrl_t                   ctrl,
  input  logic [COORD_BITS-1:0]        in_fwd_major,
  input  logic [COORD_BITS-1:0]        in_fwd_minor,
  input  logic [COORD_BITS-1:0]        in_bwd_major,
  input  logic [COORD_BITS-1:0]        in_bwd_minor,
  input  logic signed [COORD_BITS+3:0] in_decision,
  input  logic signed [COORD_BITS+3:0] in_threshold,
  input  logic signed [COORD_BITS+3:0] in_inc_two,
  input  logic [COORD_BITS-3:0]        in_steps,
  input  logic [1:0]                   in_leftover,
  output logic                         pixel_valid,
  input  logic                         pixel_ready,
  output logic [COORD_BITS-1:0]        pixel_x,
  output logic [COORD_BITS-1:0]        pixel_y,
  output logic                         last_in_item,
  output logic                         line_done
);

  localparam int DEC_W  = COORD_BITS + 4;
  localparam int STEP_W = COORD_BITS - 2;
  localparam logic [COORD_BITS-1:0] COORD_ONE = COORD_BITS'(1);
  localparam logic [COORD_BITS-1:0] COORD_TWO = COORD_BITS'(2);

  localparam logic [1:0] MODE_NONE = 2'd0;
  localparam logic [1:0] MODE_RUN  = 2'd1;
  localparam logic [1:0] MODE_ENDS = 2'd2;
  localparam logic [1:0] MODE_PAT  = 2'd3;

  localparam logic [2:0] PAT_1 = 3'd1;
  localparam logic [2:0] PAT_2 = 3'd2;
  localparam logic [2:0] PAT_3 = 3'd3;
  localparam logic [2:0] PAT_4 = 3'd4;

  function automatic logic [COORD_BITS-1:0] move_minor(input logic [COORD_BITS-1:0] v,
                                                       input logic [1:0]            d,
                                                       input logic                  neg);
    logic [COORD_BITS-1:0] dd;
    dd = {{(COORD_BITS-2){1'b0}}, d};
    return neg ? (v - dd) : (v + dd);
  endfunction

  // Line state
  logic                  line_active, swapped, minor_neg;
  logic [1:0]            line_kind;
  logic [COORD_BITS-1:0] fm, fn, bm, bn;
  logic signed [DEC_W-1:0] dec, thr, inc2;
  logic [STEP_W-1:0]     steps;
  logic [1:0]            leftover;

  // Current item
  logic       cur_valid, cur_start;
  logic [1:0] k;

  logic [1:0]            mode;
  logic [2:0]            pat;
  logic [1:0]            d1, d2, d3, dsel;
  logic                  full, last, done, emit_ok, emit, finish, pop;
  logic [1:0]            last_k;
  logic [COORD_BITS-1:0] mstep, maj, mn, fn_adv, bn_adv;
  logic signed [DEC_W-1:0] dec_adv;

  always_comb begin
    if (!line_active)                 mode = MODE_NONE;
    else if (line_kind == KIND_AXIS)  mode = MODE_RUN;
    else if (cur_start)               mode = MODE_ENDS;
    else                              mode = MODE_PAT;

    if (line_kind == KIND_SHALLOW && dec < 0)      pat = PAT_1;
    else if (line_kind != KIND_SHALLOW && dec > 0) pat = PAT_4;
    else if (dec < thr)                            pat = PAT_2;
    else                                           pat = PAT_3;

    case (pat)
      PAT_2:   begin d1 = 2'd0; d2 = 2'd1; end
      PAT_3:   begin d1 = 2'd1; d2 = 2'd1; end
      PAT_4:   begin d1 = 2'd1; d2 = 2'd2; end
      default: begin d1 = 2'd0; d2 = 2'd0; end
    endcase

    // in a half-slope line with pattern 3, the third leftover pixel only steps on a strict excess over the threshold
    d3 = (line_kind == KIND_HALF && pat == PAT_3 && !(dec > thr)) ? 2'd0 : d1;

    full  = (steps != '0);
    mstep = {{(COORD_BITS-2){1'b0}}, k[0], ~k[0]};
    dsel  = k[0] ? d2 : ((k[1] && !full) ? d3 : d1);

    fn_adv  = move_minor(fn, d2, minor_neg);
    bn_adv  = move_minor(bn, d2, !minor_neg);
    dec_adv = dec + (((pat == PAT_1) || (pat == PAT_4)) ? (thr <<< 1) : inc2);

    last_k = (leftover == 2'd0) ? 2'd0 : (leftover - 2'd1);

    case (mode)
      MODE_RUN: begin
        maj  = fm;
        mn   = fn;
        done = (fm == bm);
        last = done || (k == 2'd3);
      end
      MODE_ENDS: begin
        maj  = k[0] ? bm : fm;
        mn   = k[0] ? bn : fn;
        last = k[0];
        done = k[0] && !full && (leftover == 2'd0);
      end
      MODE_PAT: begin
        maj = k[1] ? (bm - mstep) : (fm + mstep);
        mn  = move_minor(k[1] ? bn : fn, dsel, minor_neg ^ k[1]);
        if (full) begin
          last = (k == 2'd3);
          done = last && (steps == STEP_W'(1)) && (leftover == 2'd0);
        end else begin
          last = (k == last_k);
          done = last;
        end
      end
      default: begin
        maj  = fm;
        mn   = fn;
        last = 1'b1;
        done = 1'b0;
      end
    endcase
  end

  assign emit_ok = !pixel_valid || pixel_ready;
  assign emit    = cur_valid && (mode != MODE_NONE) && emit_ok;
  assign finish  = cur_valid && ((mode == MODE_NONE) || (emit && last));
  assign q_ready = !cur_valid || finish;
  assign pop     = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_valid <= 1'b0;
      cur_valid   <= 1'b0;
      k           <= 2'd0;
      line_active <= 1'b0;
      line_kind   <= KIND_AXIS;
      steps       <= '0;
      leftover    <= 2'd0;
    end else begin
      if (emit) begin
        pixel_valid  <= 1'b1;
        pixel_x      <= swapped ? mn : maj;
        pixel_y      <= swapped ? maj : mn;
        last_in_item <= last;
        line_done    <= done;
        k            <= last ? 2'd0 : (k + 2'd1);
        case (mode)
          MODE_RUN: begin
            if (done) line_active <= 1'b0;
            else      fm          <= fm + COORD_ONE;
          end
          MODE_ENDS: begin
            if (done) line_active <= 1'b0;
          end
          MODE_PAT: begin
            if (last) begin
              if (full) begin
                fm    <= fm + COORD_TWO;
                fn    <= fn_adv;
                bm    <= bm - COORD_TWO;
                bn    <= bn_adv;
                dec   <= dec_adv;
                steps <= steps - STEP_W'(1);
              end
              if (done) line_active <= 1'b0;
            end
          end
          default: ;
        endcase
      end else if (pixel_ready) begin
        pixel_valid <= 1'b0;
      end

      if (finish) begin
        cur_valid <= 1'b0;
        k         <= 2'd0;
      end

      if (pop) begin
        cur_valid <= 1'b1;
        cur_start <= ctrl.is_start;
        k         <= 2'd0;
        if (ctrl.is_start) begin
          // a new line overrides whatever the finishing item left
          line_active <= 1'b1;
          line_kind   <= ctrl.kind;
          swapped     <= ctrl.swapped;
          minor_neg   <= ctrl.minor_neg;
          fm          <= in_fwd_major;
          fn          <= in_fwd_minor;
          bm          <= in_bwd_major;
          bn          <= in_bwd_minor;
          dec         <= in_decision;
          thr         <= in_threshold;
          inc2        <= in_inc_two;
          steps       <= in_steps;
          leftover    <= in_leftover;
        end
      end
    end
  end

  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    pixel_valid && line_done |-> last_in_item)
    else $error("line_done without last_in_item");

  a_start_activates: assert property (@(posedge clk) disable iff (rst)
    pop && ctrl.is_start |=> line_active)
    else $error("start item did not open a line");

  a_run_order: assert property (@(posedge clk) disable iff (rst)
    line_active && line_kind == KIND_AXIS |-> fm <= bm)
    else $error("axis run passed its end");

  a_steps_need_line: assert property (@(posedge clk) disable iff (rst)
    steps != '0 |-> line_active)
    else $error("patterns pending with no active line");

endmodule

>>> rtl/core/double_step_line_rasterizer.sv
// Symmetric double-step line rasterizer, top level.
// Depends on dslr_pkg, dslr_front, dslr_queue and dslr_back.
//
// Input channel (item_valid/item_ready): command 0 starts a line from
// (x_start, y_start) to (x_end, y_end); command 1 asks for the next group of
// pixels of the active line. Output channel (pixel_valid/pixel_ready): one
// pixel per transfer, with last_in_item on the final pixel an item causes and
// line_done on the final pixel of the line.
// The first pixel of an item passes the front-end stage register, a queue slot
// and the sequencer's current-item register before reaching the output register.
// Throughput: one pixel per cycle while the receiver accepts pixels; an item
// causes 1 to 4 pixels, and a continue with no active line causes none. The
// figure is set by the single output register of the pixel sequencer.
// Items are taken while earlier ones are still being drawn: a one-stage front
// end and a queue of Q_DEPTH entries (four by default) sit ahead of the sequencer.
// Reset (rst, synchronous) empties the pipeline and queue and drops any line.
// When the receiver stalls, the pixel held in the output register stays put,
// the sequencer waits, and the queue and front end fill before item_ready
// falls.
module double_step_line_rasterizer import dslr_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEFAULT,  // 8 to 16
  parameter int Q_DEPTH    = QUEUE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_ready,
  input  logic                  command,
  input  logic [COORD_BITS-1:0] x_start,
  input  logic [COORD_BITS-1:0] y_start,
  input  logic [COORD_BITS-1:0] x_end,
  input  logic [COORD_BITS-1:0] y_end,
  output logic                  pixel_valid,
  input  logic                  pixel_ready,
  output logic [COORD_BITS-1:0] pixel_x,
  output logic [COORD_BITS-1:0] pixel_y,
  output logic                  last_in_item,
  output logic                  line_done
);

  localparam int DEC_W   = COORD_BITS + 4;
  localparam int STEP_W  = COORD_BITS - 2;
  localparam int ENTRY_W = $bits(dslr_ctrl_t) + 4 * COORD_BITS + 3 * DEC_W + STEP_W + 2;

  // Front end to queue
  logic                    f_valid, f_ready;
  dslr_ctrl_t              f_ctrl;
  logic [COORD_BITS-1:0]   f_fm, f_fn, f_bm, f_bn;
  logic signed [DEC_W-1:0] f_dec, f_thr, f_inc2;
  logic [STEP_W-1:0]       f_steps;
  logic [1:0]              f_left;

  // Queue to back end
  logic                    b_valid, b_ready;
  dslr_ctrl_t              b_ctrl;
  logic [COORD_BITS-1:0]   b_fm, b_fn, b_bm, b_bn;
  logic signed [DEC_W-1:0] b_dec, b_thr, b_inc2;
  logic [STEP_W-1:0]       b_steps;
  logic [1:0]              b_left;

  logic [ENTRY_W-1:0]      wr_entry, rd_entry;

  dslr_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .command    (command),
    .x_start    (x_start),
    .y_start    (y_start),
    .x_end      (x_end),
    .y_end      (y_end),
    .q_valid    (f_valid),
    .q_ready    (f_ready),
    .ctrl       (f_ctrl),
    .fwd_major  (f_fm),
    .fwd_minor  (f_fn),
    .bwd_major  (f_bm),
    .bwd_minor  (f_bn),
    .decision   (f_dec),
    .threshold  (f_thr),
    .inc_two    (f_inc2),
    .steps      (f_steps),
    .leftover   (f_left)
  );

  assign wr_entry = {f_ctrl, f_fm, f_fn, f_bm, f_bn, f_dec, f_thr, f_inc2, f_steps, f_left};

  dslr_queue #(.WIDTH(ENTRY_W), .DEPTH(Q_DEPTH)) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_data  (wr_entry),
    .rd_valid (b_valid),
    .rd_ready (b_ready),
    .rd_data  (rd_entry)
  );

  assign {b_ctrl, b_fm, b_fn, b_bm, b_bn, b_dec, b_thr, b_inc2, b_steps, b_left} = rd_entry;

  dslr_back #(.COORD_BITS(COORD_BITS)) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (b_valid),
    .q_ready      (b_ready),
    .ctrl         (b_ctrl),
    .in_fwd_major (b_fm),
    .in_fwd_minor (b_fn),
    .in_bwd_major (b_bm),
    .in_bwd_minor (b_bn),
    .in_decision  (b_dec),
    .in_threshold (b_thr),
    .in_inc_two   (b_inc2),
    .in_steps     (b_steps),
    .in_leftover  (b_left),
    .pixel_valid  (pixel_valid),
    .pixel_ready  (pixel_ready),
    .pixel_x      (pixel_x),
    .pixel_y      (pixel_y),
    .last_in_item (last_in_item),
    .line_done    (line_done)
  );

endmodule
